// ===== rtl/core/imufd_pkg.sv =====
// ----------------------------------------------------------------------------
// imufd_pkg
// Shared types and constants of the imu frame deframer.
// ----------------------------------------------------------------------------
package imufd_pkg;

    // frame layout
    localparam int CHANNELS = 16;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W    = $clog2(CHANNELS + 1);

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 24;
    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 25;
    localparam int MDATA_W = 32;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SYNC    = 2'd0;
    localparam logic [1:0] REG_TRAILER = 2'd1;
    localparam logic [1:0] REG_OFFSET  = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'h50;
    localparam logic [WORD_W-1:0] TRAILER_RESET = 24'd1128000;
    localparam logic [WORD_W-1:0] OFFSET_RESET  = 24'd1000000;

    // word store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } store_wr_t;

endpackage

// ===== rtl/core/imufd_ram.sv =====
// ----------------------------------------------------------------------------
// imufd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module imufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/imufd_framer.sv =====
// ----------------------------------------------------------------------------
// imufd_framer
// Hunts for the sync byte, assembles big-endian 24-bit words, writes them
// into the word store and checks the trailer at the end of the frame.
// ----------------------------------------------------------------------------
module imufd_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    output logic                          byte_ready,
    input  logic [imufd_pkg::BYTE_W-1:0]  byte_data,
    input  logic [imufd_pkg::BYTE_W-1:0]  sync_byte,
    input  logic [imufd_pkg::WORD_W-1:0]  trailer_word,
    input  logic                          drain_busy,
    output imufd_pkg::store_wr_t          store_wr,
    output logic                          drain_start
);
    import imufd_pkg::*;

    localparam logic [1:0] PH_HIGH = 2'd0;
    localparam logic [1:0] PH_MID  = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic              hunt_reg,    hunt_next;
    logic [1:0]        phase_reg,   phase_next;
    logic [IDX_W-1:0]  idx_reg,     idx_next;
    logic [15:0]       partial_reg, partial_next;
    logic              start_reg,   start_next;
    logic              accept;
    logic [WORD_W-1:0] word;

    assign byte_ready = !drain_busy && !start_reg;
    assign accept     = byte_valid && byte_ready;
    assign word       = {partial_reg, byte_data};

    // byte sequencing
    always_comb begin
        hunt_next    = hunt_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        partial_next = partial_reg;
        start_next   = 1'b0;
        store_wr     = '0;
        store_wr.addr = idx_reg[ADDR_W-1:0];
        store_wr.data = word;
        if (accept) begin
            if (hunt_reg) begin
                if (byte_data == sync_byte) begin
                    hunt_next  = 1'b0;
                    phase_next = PH_HIGH;
                    idx_next   = '0;
                end
            end else begin
                unique case (phase_reg)
                    PH_HIGH: begin
                        partial_next = {8'd0, byte_data};
                        phase_next   = PH_MID;
                    end
                    PH_MID: begin
                        partial_next = {partial_reg[7:0], byte_data};
                        phase_next   = PH_LOW;
                    end
                    PH_LOW: begin
                        phase_next = PH_HIGH;
                        if (idx_reg == IDX_W'(CHANNELS)) begin
                            // trailer word closes the frame
                            hunt_next  = 1'b1;
                            start_next = (word == trailer_word);
                        end else begin
                            store_wr.we = 1'b1;
                            idx_next    = idx_reg + IDX_W'(1);
                        end
                    end
                    default: begin
                        phase_next = PH_HIGH;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hunt_reg    <= 1'b1;
            phase_reg   <= PH_HIGH;
            idx_reg     <= '0;
            partial_reg <= '0;
            start_reg   <= 1'b0;
        end else begin
            hunt_reg    <= hunt_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            partial_reg <= partial_next;
            start_reg   <= start_next;
        end
    end

    assign drain_start = start_reg;

endmodule

// ===== rtl/core/imufd_drain.sv =====
// ----------------------------------------------------------------------------
// imufd_drain
// Reads the stored words back one channel at a time, removes the offset in
// one shared subtractor and hands each result to the output register.
// ----------------------------------------------------------------------------
module imufd_drain (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [imufd_pkg::WORD_W-1:0]         value_offset,
    output logic                                 busy,
    output logic                                 rd_en,
    output logic [imufd_pkg::ADDR_W-1:0]         rd_addr,
    input  logic [imufd_pkg::WORD_W-1:0]         rd_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [imufd_pkg::CHAN_W-1:0]         out_channel,
    output logic signed [imufd_pkg::VALUE_W-1:0] out_value,
    output logic                                 out_last
);
    import imufd_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [ADDR_W-1:0]         cnt_reg,   cnt_next;
    logic                      valid_reg, valid_next;
    logic [CHAN_W-1:0]         chan_reg,  chan_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      last_reg,  last_next;
    logic                      is_last;
    logic                      slot_free;
    logic signed [VALUE_W-1:0] diff;

    // shared subtract unit
    assign diff = $signed({1'b0, rd_data}) - $signed({1'b0, value_offset});

    assign is_last   = (cnt_reg == ADDR_W'(CHANNELS - 1));
    assign slot_free = !valid_reg || out_ready;

    // channel sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        chan_next  = chan_reg;
        value_next = value_reg;
        last_next  = last_reg;
        rd_en      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cnt_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    chan_next  = CHAN_W'(cnt_reg);
                    value_next = diff;
                    last_next  = is_last;
                    if (is_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + ADDR_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        chan_reg  <= chan_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign rd_addr     = cnt_reg;
    assign out_valid   = valid_reg;
    assign out_channel = chan_reg;
    assign out_value   = value_reg;
    assign out_last    = last_reg;

endmodule

// ===== rtl/core/imu_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Byte stream to channel values: sync hunt, 24-bit word assembly, trailer
// check and offset removal, with an apb register port.
// ----------------------------------------------------------------------------
// flow: bytes are accepted while s_tready is high; a good trailer beat is registered
//   as the drain start, then each word is read from the ram into its read register
//   and passed through the subtractor into the output register, one word at a time
// input: after a good trailer s_tready stays low (also through output stalls)
//   while the words are read back through the single ram read port and the one shared subtractor
// reset: synchronous, active low; registers return to defaults, sync hunt
module imu_frame_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input bytes
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [imufd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [imufd_pkg::MDATA_W-1:0]  m_tdata,   // [3:0] channel, [28:4] value, zero pad
    output logic                           m_tlast,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [imufd_pkg::PADDR_W-1:0]  paddr,
    input  logic [imufd_pkg::PDATA_W-1:0]  pwdata,
    output logic [imufd_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import imufd_pkg::*;

    logic [BYTE_W-1:0]         sync_reg,    sync_next;
    logic [WORD_W-1:0]         trailer_reg, trailer_next;
    logic [WORD_W-1:0]         offset_reg,  offset_next;
    logic                      wr_en;
    logic [1:0]                reg_idx;
    store_wr_t                 store_wr;
    logic                      drain_start;
    logic                      drain_busy;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic [WORD_W-1:0]         rd_data;
    logic [CHAN_W-1:0]         out_channel;
    logic signed [VALUE_W-1:0] out_value;

    // register decode
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        sync_next    = sync_reg;
        trailer_next = trailer_reg;
        offset_next  = offset_reg;
        prdata       = '0;
        unique case (reg_idx)
            REG_SYNC: begin
                prdata = PDATA_W'(sync_reg);
                if (wr_en) sync_next = pwdata[BYTE_W-1:0];
            end
            REG_TRAILER: begin
                prdata = PDATA_W'(trailer_reg);
                if (wr_en) trailer_next = pwdata[WORD_W-1:0];
            end
            REG_OFFSET: begin
                prdata = PDATA_W'(offset_reg);
                if (wr_en) offset_next = pwdata[WORD_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            trailer_reg <= TRAILER_RESET;
            offset_reg  <= OFFSET_RESET;
        end else begin
            sync_reg    <= sync_next;
            trailer_reg <= trailer_next;
            offset_reg  <= offset_next;
        end
    end

    // byte framing
    imufd_framer u_framer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid   (s_tvalid),
        .byte_ready   (s_tready),
        .byte_data    (s_tdata),
        .sync_byte    (sync_reg),
        .trailer_word (trailer_reg),
        .drain_busy   (drain_busy),
        .store_wr     (store_wr),
        .drain_start  (drain_start)
    );

    // word store
    imufd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .aclk  (aclk),
        .we    (store_wr.we),
        .waddr (store_wr.addr),
        .wdata (store_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // readback and offset removal
    imufd_drain u_drain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (drain_start),
        .value_offset (offset_reg),
        .busy         (drain_busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_channel  (out_channel),
        .out_value    (out_value),
        .out_last     (m_tlast)
    );

    assign m_tdata = {{(MDATA_W - CHAN_W - VALUE_W){1'b0}}, out_value, out_channel};

endmodule

// ===== rtl/core/imufd_checker.sv =====
// ----------------------------------------------------------------------------
// imufd_checker
// Port-level checks of the imu frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module imufd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [imufd_pkg::MDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // a stalled result beat stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // while a frame is still being drained no new byte is taken
    a_drain_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a frame readback");

endmodule

bind imu_frame_deframer imufd_checker u_imufd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
